// ===== design/ort_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ort_pkg
// Shared widths, codes and reset values for the outstanding request tracker.
// ----------------------------------------------------------------------------
package ort_pkg;

    localparam int OP_W      = 2;
    localparam int ID_W      = 32;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 31;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    // operation codes carried on op
    localparam logic [OP_W-1:0] OP_CALL = 2'd0;
    localparam logic [OP_W-1:0] OP_RESP = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic ST_RESP    = 1'b0;
    localparam logic ST_TIMEOUT = 1'b1;

    // register select is paddr[2]
    localparam logic REG_TIMEOUT = 1'b0;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 31'd3000;
    localparam logic [ID_W-1:0]      ID_FIRST      = 32'd1;

endpackage : ort_pkg
`default_nettype wire

// ===== design/outstanding_request_tracker_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// outstanding_request_tracker_unit
// Slot table of outstanding requests with id assignment and deadline expiry.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one item: a call, a response or a
// tick. in_stall stays high while an item is being worked on; items are
// handled one at a time by a small sequencer that walks the slot table.
// Output channel (out_valid/out_stall) delivers result items from an output
// register; last marks the final result of an input item.
// A call scans the slots from 0 up to the first free one. A response or tick
// visits the slots in order, each visit being a slot memory read and then one
// pass through the shared 32-bit add/compare unit, and finishes with a closing
// step; a response stops at its match.
// A tick that reports timeouts holds one result in a staging register; when
// the receiver stalls, the walk pauses on the next report until the output
// register frees up, so nothing is dropped.
// Reset clears the slot valid bits, the output register, the id counter (1)
// and the timeout register (3000). The slot memory is not cleared.
// timeout_ms is written over the APB port when paddr[2] is low; pready is always high.
// ----------------------------------------------------------------------------
module outstanding_request_tracker_unit #(
    parameter int SLOTS    = 10,
    parameter int TAG_BITS = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input items
    input  wire logic                        in_valid,
    output      logic                        in_stall,
    input  wire logic [ort_pkg::OP_W-1:0]    op,
    input  wire logic [ort_pkg::ID_W-1:0]    msg_id,
    input  wire logic [ort_pkg::TIME_W-1:0]  now_ms,
    input  wire logic                        send_ok,
    input  wire logic [TAG_BITS-1:0]         caller_tag,
    input  wire logic                        wants_completion,
    // result items
    output      logic                        out_valid,
    input  wire logic                        out_stall,
    output      logic                        kind,
    output      logic [ort_pkg::ID_W-1:0]    msg_id_res,
    output      logic [TAG_BITS-1:0]         caller_tag_res,
    output      logic                        status,
    output      logic                        last,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ort_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ort_pkg::DATA_W-1:0]  pwdata,
    output      logic [ort_pkg::DATA_W-1:0]  prdata,
    output      logic                        pready
);
    import ort_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALL,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                kind;
        logic [ID_W-1:0]     id;
        logic [TAG_BITS-1:0] tag;
        logic                status;
    } res_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [SLOTS-1:0]       valid_reg, valid_next;
    logic [ID_W-1:0]        next_id_reg, next_id_next;
    logic [TIMEOUT_W-1:0]   timeout_reg, timeout_next;

    // latched input item
    logic [OP_W-1:0]        op_reg, op_next;
    logic [ID_W-1:0]        mid_reg, mid_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic                   sent_reg, sent_next;
    logic [TAG_BITS-1:0]    tag_reg, tag_next;
    logic                   notify_reg, notify_next;

    // staging and output registers
    logic                   pend_valid_reg, pend_valid_next;
    res_t                   pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    res_t                   out_res_reg, out_res_next;
    logic                   out_last_reg, out_last_next;

    // slot memory and its registered read data
    logic [ID_W-1:0]        mem_id     [SLOTS];
    logic [TIME_W-1:0]      mem_dl     [SLOTS];
    logic [TAG_BITS-1:0]    mem_tag    [SLOTS];
    logic                   mem_notify [SLOTS];
    logic [ID_W-1:0]        rd_id_reg;
    logic [TIME_W-1:0]      rd_dl_reg;
    logic [TAG_BITS-1:0]    rd_tag_reg;
    logic                   rd_notify_reg;
    logic                   wr_en;

    // shared add/subtract unit
    logic [TIME_W-1:0]      alu_a, alu_b, alu_sum;
    logic                   alu_sub;

    logic                   in_accept;
    logic                   out_free;
    logic                   hit;
    logic                   cfg_write;
    logic [ID_W-1:0]        id_use;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT);

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMEOUT) ? {1'b0, timeout_reg} : '0;

    assign out_valid      = out_valid_reg;
    assign kind           = out_res_reg.kind;
    assign msg_id_res     = out_res_reg.id;
    assign caller_tag_res = out_res_reg.tag;
    assign status         = out_res_reg.status;
    assign last           = out_last_reg;

    assign id_use = (next_id_reg == '0) ? ID_FIRST : next_id_reg;

    always_comb
    begin
        if (state_reg == S_CALL)
        begin
            alu_a   = now_reg;
            alu_b   = {1'b0, timeout_reg};
            alu_sub = 1'b0;
        end
        else if (op_reg == OP_RESP)
        begin
            alu_a   = mid_reg;
            alu_b   = rd_id_reg;
            alu_sub = 1'b1;
        end
        else
        begin
            alu_a   = now_reg;
            alu_b   = rd_dl_reg;
            alu_sub = 1'b1;
        end
        alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(TIME_W-1){1'b0}}, alu_sub};
    end

    // response: exact id match; tick: deadline reached (wrap-safe sign test)
    assign hit = valid_reg[idx_reg] &&
                 ((op_reg == OP_RESP) ? (alu_sum == '0) : !alu_sum[TIME_W-1]);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        next_id_next    = next_id_reg;
        timeout_next    = timeout_reg;
        op_next         = op_reg;
        mid_next        = mid_reg;
        now_next        = now_reg;
        sent_next       = sent_reg;
        tag_next        = tag_reg;
        notify_next     = notify_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;

        if (cfg_write)
        begin
            timeout_next = pwdata[TIMEOUT_W-1:0];
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next     = op;
                    mid_next    = msg_id;
                    now_next    = now_ms;
                    sent_next   = send_ok;
                    tag_next    = caller_tag;
                    notify_next = wants_completion;
                    idx_next    = '0;
                    case (op)
                        OP_CALL: state_next = S_CALL;
                        OP_RESP: state_next = S_READ;
                        OP_TICK: state_next = S_READ;
                        default: state_next = S_IDLE;
                    endcase
                end
            end

            S_CALL:
            begin
                if (!valid_reg[idx_reg])
                begin
                    next_id_next    = id_use + ID_FIRST;
                    pend_valid_next = 1'b1;
                    pend_next       = '{kind: KIND_ACK, id: '0, tag: '0, status: ST_RESP};
                    if (sent_reg)
                    begin
                        valid_next[idx_reg] = 1'b1;
                        wr_en               = 1'b1;
                        pend_next.id        = id_use;
                    end
                    state_next = S_DONE;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    // table full: refused, id not consumed
                    pend_valid_next = 1'b1;
                    pend_next       = '{kind: KIND_ACK, id: '0, tag: '0, status: ST_RESP};
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_READ:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (hit && rd_notify_reg && pend_valid_reg && !out_free)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    if (hit)
                    begin
                        valid_next[idx_reg] = 1'b0;
                    end
                    if (hit && rd_notify_reg)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_res_next   = pend_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = '{kind: KIND_DONE, id: rd_id_reg, tag: rd_tag_reg,
                                            status: (op_reg == OP_RESP) ? ST_RESP : ST_TIMEOUT};
                    end
                    if ((op_reg == OP_RESP && hit) || idx_reg == IDX_LAST)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end

            S_DONE:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_res_next    = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            next_id_reg    <= ID_FIRST;
            timeout_reg    <= TIMEOUT_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_res_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            next_id_reg    <= next_id_next;
            timeout_reg    <= timeout_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            out_res_reg    <= out_res_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        mid_reg      <= mid_next;
        now_reg      <= now_next;
        sent_reg     <= sent_next;
        tag_reg      <= tag_next;
        notify_reg   <= notify_next;
        pend_reg     <= pend_next;
    end

    // slot memory: written on a kept call, read one slot per walk step
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_id[idx_reg]     <= id_use;
            mem_dl[idx_reg]     <= alu_sum;
            mem_tag[idx_reg]    <= tag_reg;
            mem_notify[idx_reg] <= notify_reg;
        end
        if (state_reg == S_READ)
        begin
            rd_id_reg     <= mem_id[idx_reg];
            rd_dl_reg     <= mem_dl[idx_reg];
            rd_tag_reg    <= mem_tag[idx_reg];
            rd_notify_reg <= mem_notify[idx_reg];
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("staged result left behind when returning to idle");

    a_ack_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_ACK) |-> (last && caller_tag_res == '0 && status == ST_RESP))
        else $error("call acknowledgement with bad last, tag or status");

    a_idle_slots_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> $stable(valid_reg))
        else $error("slot valid bits changed while idle");
`endif

endmodule : outstanding_request_tracker_unit
`default_nettype wire
